// ===== rtl/debounced_press_timer_blinker_top_assert.svh =====
// Assertion macros shared by the debounce/press-timer RTL.
// Included by modules that check their own logic; empty under SYNTHESIS.
`ifndef DEBOUNCED_PRESS_TIMER_BLINKER_TOP_ASSERT_SVH
`define DEBOUNCED_PRESS_TIMER_BLINKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dpt assertion failed");
`define DPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dpt assertion failed");
`else
`define DPT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/dpt_pkg.sv =====
// Package for the debounce/press-timer block: constants and lane result type.
// No dependencies.
`timescale 1ns / 1ps
package dpt_pkg;
	localparam int OUT_CH = 3;
	localparam int STABLE_BITS = 9;
	localparam logic [STABLE_BITS-1:0] STABLE_MAX = 9'd511;
	localparam logic [7:0] DEBOUNCE_RESET = 8'd50;
	localparam int DUR_BITS = 16;
	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [3:0] BLINK_ABOVE = 4'd4;
	localparam int IN_W = 8;
	localparam int OUT_W = 56;

	typedef struct packed {
		logic led;
		logic released;
		logic [DUR_BITS-1:0] duration;
	} lane_res_t;
endpackage

// ===== rtl/dpt_lane.sv =====
// One button channel: debounce, press timer, release report and blink.
// Uses dpt_pkg and the assertion header.
`timescale 1ns / 1ps
`include "debounced_press_timer_blinker_top_assert.svh"
module dpt_lane #(
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                raw,
	input  logic                tick,
	input  logic [7:0]          debounce_ms,
	output dpt_pkg::lane_res_t  res
);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                            prev_q, acc_q, armed_q, flash_q, led_q;
	logic [dpt_pkg::STABLE_BITS-1:0] stable_q, stable_d;
	logic [COUNT_BITS-1:0]           cnt_q, cnt_d;
	logic [3:0]                      dig_q, dig_d;
	logic                            acc_d, armed_d, flash_d, led_d, rel;
	logic [COUNT_BITS-1:0]           cnt_m;
	logic [3:0]                      dig_m;

	always_comb begin
		if (raw != prev_q) begin
			stable_d = '0;
		end else if (stable_q < dpt_pkg::STABLE_MAX) begin
			stable_d = stable_q + 1'b1;
		end else begin
			stable_d = stable_q;
		end
		acc_d = (stable_d > {1'b0, debounce_ms}) ? raw : acc_q;

		led_d   = led_q;
		armed_d = armed_q;
		flash_d = flash_q;
		cnt_m   = cnt_q;
		dig_m   = dig_q;
		if (acc_d) begin
			led_d = 1'b1;
			if (armed_q) begin
				cnt_m   = '0;
				dig_m   = '0;
				armed_d = 1'b0;
				flash_d = 1'b0;
			end
		end
		rel = !acc_d && !armed_d;
		if (rel) begin
			armed_d = 1'b1;
			flash_d = 1'b1;
		end
		// dig tracks count mod 10
		if (cnt_m != '0 && flash_d) begin
			led_d = dig_m > dpt_pkg::BLINK_ABOVE;
		end

		cnt_d = cnt_m;
		dig_d = dig_m;
		if (tick) begin
			if (!flash_d) begin
				if (cnt_m != CNT_MAX) begin
					cnt_d = cnt_m + 1'b1;
					dig_d = (dig_m == dpt_pkg::DIGIT_MAX) ? 4'd0 : dig_m + 4'd1;
				end
			end else if (cnt_m != '0) begin
				cnt_d = cnt_m - 1'b1;
				dig_d = (dig_m == 4'd0) ? dpt_pkg::DIGIT_MAX : dig_m - 4'd1;
			end
		end

		res.led      = led_d;
		res.released = rel;
		res.duration = rel ? dpt_pkg::DUR_BITS'(cnt_m) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			stable_q <= '0;
			acc_q    <= 1'b0;
			armed_q  <= 1'b1;
			flash_q  <= 1'b0;
			cnt_q    <= '0;
			dig_q    <= '0;
			led_q    <= 1'b0;
		end else if (in_fire) begin
			prev_q   <= raw;
			stable_q <= stable_d;
			acc_q    <= acc_d;
			armed_q  <= armed_d;
			flash_q  <= flash_d;
			cnt_q    <= cnt_d;
			dig_q    <= dig_d;
			led_q    <= led_d;
		end
	end

	`DPT_ASSERT_SAME(a_dig_range, clk, arst_n, 1'b1, dig_q <= dpt_pkg::DIGIT_MAX)
	`DPT_ASSERT_SAME(a_zero_dig, clk, arst_n, cnt_q == '0, dig_q == 4'd0)
	`DPT_ASSERT_NEXT(a_rel_arms, clk, arst_n, in_fire && res.released, armed_q && flash_q)
endmodule

// ===== rtl/dpt_merge.sv =====
// Merges lane results into one output item and queues it (two entries).
// Uses dpt_pkg and the assertion header.
`timescale 1ns / 1ps
`include "debounced_press_timer_blinker_top_assert.svh"
module dpt_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  dpt_pkg::lane_res_t            res [dpt_pkg::OUT_CH],
	output logic                          s_tready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dpt_pkg::OUT_W-1:0]     m_tdata
);
	logic [dpt_pkg::OUT_W-1:0] item;
	logic [dpt_pkg::OUT_W-1:0] ent_q [2];
	logic                      wr_q, rd_q;
	logic [1:0]                cnt_q;
	logic                      pop, wr;

	// led[2:0], released[5:3], dur0[21:6], dur1[37:22], dur2[53:38], zero pad
	assign item = {2'b00, res[2].duration, res[1].duration, res[0].duration,
		res[2].released, res[1].released, res[0].released,
		res[2].led, res[1].led, res[0].led};

	assign s_tready = cnt_q != 2'd2;
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = ent_q[rd_q];
	assign pop      = m_tvalid && m_tready;
	assign wr       = push && s_tready;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, pop};
		end
	end

	`DPT_ASSERT_SAME(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`DPT_ASSERT_SAME(a_ptr_sync, clk, arst_n, cnt_q == 2'd0 || cnt_q == 2'd2, wr_q == rd_q)
	`DPT_ASSERT_NEXT(a_pop_only, clk, arst_n, pop && !wr, cnt_q == $past(cnt_q) - 2'd1)
endmodule

// ===== rtl/debounced_press_timer_blinker_top.sv =====
// Debounced three-button press timer with blinking LEDs, one lane per channel.
// A result item is written into the output queue register when its input item is accepted.
// Throughput: one item per cycle; a two-entry output queue decouples the sides,
// so s_tready drops only when two results wait.
// Reset (arst_n low): all channel state cleared, lanes armed, debounce_ms = 50.
// Depends on dpt_pkg, dpt_lane, dpt_merge.
`timescale 1ns / 1ps
module debounced_press_timer_blinker_top #(
	parameter int CHANNELS   = 3,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dpt_pkg::IN_W-1:0]      s_tdata,  // raw_buttons[2:0], tenth_tick[3], pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dpt_pkg::OUT_W-1:0]     m_tdata,  // led_levels, released_mask, dur0..2
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_wdata
);
	logic [7:0]         debounce_q;
	logic               in_fire;
	dpt_pkg::lane_res_t lane_res [CHANNELS];
	dpt_pkg::lane_res_t out_res  [dpt_pkg::OUT_CH];

	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= dpt_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		logic raw;
		if (g < dpt_pkg::OUT_CH) begin : g_pin
			assign raw = s_tdata[g];
		end else begin : g_nopin
			assign raw = 1'b0;
		end
		dpt_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.in_fire     (in_fire),
			.raw         (raw),
			.tick        (s_tdata[3]),
			.debounce_ms (debounce_q),
			.res         (lane_res[g])
		);
	end

	for (genvar k = 0; k < dpt_pkg::OUT_CH; k++) begin : g_out
		if (k < CHANNELS) begin : g_used
			assign out_res[k] = lane_res[k];
		end else begin : g_none
			assign out_res[k] = '0;
		end
	end

	dpt_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid),
		.res      (out_res),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for debounced_press_timer_blinker_top: streams one-ms button samples, predicts
// every result item in a scoreboard class and compares it field by field.
// Depends on dpt_pkg and the block's RTL.

typedef struct packed {
	logic [dpt_pkg::DUR_BITS-1:0] dur2;
	logic [dpt_pkg::DUR_BITS-1:0] dur1;
	logic [dpt_pkg::DUR_BITS-1:0] dur0;
	logic [2:0]                   released;
	logic [2:0]                   leds;
} sample_result_t;

class press_timer_board;
	logic [7:0]                       debounce_ms;
	logic                             prev_raw [dpt_pkg::OUT_CH];
	logic [dpt_pkg::STABLE_BITS-1:0]  stable_ms [dpt_pkg::OUT_CH];
	logic                             level [dpt_pkg::OUT_CH];
	logic                             armed [dpt_pkg::OUT_CH];
	logic                             flashing [dpt_pkg::OUT_CH];
	logic                             led_hold [dpt_pkg::OUT_CH];
	logic [dpt_pkg::DUR_BITS-1:0]     tenths [dpt_pkg::OUT_CH];
	sample_result_t                   expected_samples [$];
	int unsigned                      mismatches;
	int unsigned                      samples_checked;

	function new();
		debounce_ms = dpt_pkg::DEBOUNCE_RESET;
		for (int c = 0; c < dpt_pkg::OUT_CH; c++) begin
			prev_raw[c] = 1'b0;
			stable_ms[c] = '0;
			level[c] = 1'b0;
			armed[c] = 1'b1;
			flashing[c] = 1'b0;
			led_hold[c] = 1'b0;
			tenths[c] = '0;
		end
		mismatches = 0;
		samples_checked = 0;
	endfunction

	function void take_sample(logic [2:0] raw, logic tick);
		sample_result_t res;
		logic [dpt_pkg::DUR_BITS-1:0] dur [dpt_pkg::OUT_CH];
		res = '0;
		for (int c = 0; c < dpt_pkg::OUT_CH; c++) begin
			dur[c] = '0;
			if (raw[c] != prev_raw[c])
				stable_ms[c] = '0;
			else if (stable_ms[c] != dpt_pkg::STABLE_MAX)
				stable_ms[c]++;
			if (stable_ms[c] > {1'b0, debounce_ms})
				level[c] = raw[c];
			if (level[c]) begin
				led_hold[c] = 1'b1;
				if (armed[c]) begin
					tenths[c] = '0;
					armed[c] = 1'b0;
					flashing[c] = 1'b0;
				end
			end
			if (!level[c] && !armed[c]) begin
				res.released[c] = 1'b1;
				dur[c] = tenths[c];
				armed[c] = 1'b1;
				flashing[c] = 1'b1;
			end
			// zero count on release: LED keeps its last level
			if (tenths[c] != 0 && flashing[c])
				led_hold[c] = (tenths[c] % (dpt_pkg::DIGIT_MAX + 1)) > dpt_pkg::BLINK_ABOVE;
			prev_raw[c] = raw[c];
			res.leds[c] = led_hold[c];
		end
		if (tick) begin
			for (int c = 0; c < dpt_pkg::OUT_CH; c++) begin
				if (!flashing[c]) begin
					if (tenths[c] != '1)
						tenths[c]++;
				end else if (tenths[c] != 0) begin
					tenths[c]--;
				end
			end
		end
		res.dur0 = dur[0];
		res.dur1 = dur[1];
		res.dur2 = dur[2];
		expected_samples.push_back(res);
	endfunction

	function void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_sample(logic [dpt_pkg::OUT_W-1:0] data);
		sample_result_t want;
		sample_result_t got;
		got = data[$bits(sample_result_t)-1:0];
		if (expected_samples.size() == 0) begin
			$display("%0t: result item expected none got %h", $time, got);
			mismatches++;
			return;
		end
		want = expected_samples.pop_front();
		samples_checked++;
		compare_field("led_levels", 16'(want.leds), 16'(got.leds));
		compare_field("released_mask", 16'(want.released), 16'(got.released));
		compare_field("duration_ch0", want.dur0, got.dur0);
		compare_field("duration_ch1", want.dur1, got.dur1);
		compare_field("duration_ch2", want.dur2, got.dur2);
	endfunction
endclass

module testbench;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned SAT_HOLD = 520;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [dpt_pkg::IN_W-1:0]  s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [dpt_pkg::OUT_W-1:0] m_tdata;
	logic                      cfg_we;
	logic [7:0]                cfg_wdata;

	press_timer_board board = new();
	logic        calm = 1'b0;
	int unsigned samples_sent = 0;
	int unsigned cycle_count = 0;

	debounced_press_timer_blinker_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[debounced_press_timer_blinker_top] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.take_sample(s_tdata[2:0], s_tdata[3]);
			if (m_tvalid && m_tready)
				board.check_sample(m_tdata);
		end
	end

	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin : ready_side
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			stall = idle_gap();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	task automatic send_sample(input logic [2:0] raw, input logic tick);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, tick, raw};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
		gap = idle_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.samples_checked != samples_sent)
			@(posedge clk);
	endtask

	task automatic write_debounce(input logic [7:0] value);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.debounce_ms = value;
	endtask

	// settled holds, long holds for blinking, short glitches and pure noise
	task automatic run_segment(inout int unsigned budget);
		int unsigned kind;
		int unsigned len;
		int unsigned tick_pct;
		logic [2:0]  raw;
		kind = $urandom_range(0, 9);
		raw = 3'($urandom_range(0, 7));
		tick_pct = $urandom_range(20, 100);
		calm = ($urandom_range(0, 9) == 0);
		if (kind < 7)
			len = board.debounce_ms + 2 + $urandom_range(0, 10);
		else if (kind == 7)
			len = board.debounce_ms + 2 + $urandom_range(20, 60);
		else
			len = $urandom_range(1, board.debounce_ms + 2);
		repeat (len) begin
			if (kind == 9)
				raw = 3'($urandom_range(0, 7));
			send_sample(raw, $urandom_range(0, 99) < tick_pct);
			if (budget != 0)
				budget--;
		end
	endtask

	task automatic random_phase(input int unsigned items);
		int unsigned left;
		left = items;
		while (left != 0)
			run_segment(left);
		calm = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		random_phase(80);

		write_debounce(8'd0);
		send_sample(3'b111, 1'b0);
		send_sample(3'b111, 1'b0);
		send_sample(3'b110, 1'b0);
		send_sample(3'b110, 1'b0);
		repeat (7) send_sample(3'b110, 1'b1);
		send_sample(3'b000, 1'b1);
		send_sample(3'b000, 1'b1);
		repeat (7) send_sample(3'b000, 1'b1);
		send_sample(3'b101, 1'b0);
		send_sample(3'b000, 1'b0);
		send_sample(3'b001, 1'b1);
		send_sample(3'b001, 1'b1);
		send_sample(3'b000, 1'b0);
		random_phase(60);

		write_debounce(8'd1);
		random_phase(50);
		write_debounce(8'd3);
		random_phase(50);
		write_debounce(8'($urandom_range(0, 20)));
		random_phase(50);

		// hold long enough to saturate the stable counter at the top debounce value
		calm = 1'b1;
		write_debounce(8'd255);
		repeat (SAT_HOLD) send_sample(3'b111, 1'b1);
		repeat (260) send_sample(3'b000, 1'b0);
		repeat (20) send_sample(3'b000, 1'b1);
		calm = 1'b0;

		write_debounce(8'($urandom_range(2, 9)));
		random_phase(60);

		wait_drained();
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.expected_samples.size() == 0)
			$display("[debounced_press_timer_blinker_top] OK");
		else
			$display("[debounced_press_timer_blinker_top] ERROR");
		$finish;
	end
endmodule
